>>> sv/mecanum_wheel_speed_scaler_unit_defines.svh
// ----------------------------------------------------------------------------
// Mecanum wheel speed scaler: assertion macros
// Shared concurrent assertion forms used by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_SPEED_SCALER_UNIT_DEFINES_SVH
`define MECANUM_WHEEL_SPEED_SCALER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MWSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with a fixed delay, disabled while reset is low
`define MWSS_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

>>> sv/mwss_pkg.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed scaler: package
// Widths, pipeline depths and the bundles passed between pipeline sections.
// ----------------------------------------------------------------------------
`default_nettype none

package mwss_pkg;

    // field widths
    localparam int LANES      = 4;
    localparam int VEL_W      = 13;
    localparam int YAW_W      = 16;
    localparam int ARM_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int SPD_W      = 16;

    // internal widths
    localparam int SUM_W      = 15;                 // -x +/- y
    localparam int TURN_W     = YAW_W + ARM_W + 1;  // w * R
    localparam int LIN_FRAC   = 18;                 // fraction bits of wheel speed
    localparam int LIN_W      = 34;                 // wheel linear speed
    localparam int PROD_W     = LIN_W + GAIN_W + 1; // speed times gain
    localparam int FRAC_SHIFT = 26;                 // fraction bits of the product
    localparam int MAG_W      = 22;                 // wheel rpm magnitude
    localparam int QUO_W      = LIMIT_W;            // rescaled magnitude
    localparam int NUM_W      = MAG_W + LIMIT_W;    // dividend of the rescale

    // motors one and three change sign
    localparam logic [LANES-1:0] FLIP_MASK = 4'b0101;

    // pipeline depths
    localparam int KIN_DEPTH  = 4;
    localparam int PEAK_DEPTH = 3;
    localparam int LATENCY    = KIN_DEPTH + PEAK_DEPTH + QUO_W + 1;

    // wheel magnitudes after gain and truncation
    typedef struct packed {
        logic                         valid;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][MAG_W-1:0]  mag;
    } t_wheel_mag;

    // rescale request: one shared divisor, one dividend per wheel
    typedef struct packed {
        logic                         valid;
        logic                         scaled;
        logic [LANES-1:0]             neg;
        logic [MAG_W-1:0]             divisor;
        logic [LANES-1:0][NUM_W-1:0]  num;
    } t_div_req;

    // rescale result
    typedef struct packed {
        logic                         valid;
        logic                         scaled;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][QUO_W-1:0]  quo;
    } t_div_res;

endpackage

`default_nettype wire

>>> sv/mecanum_wheel_speed_scaler_unit.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed scaler unit
// Four-wheel mecanum inverse kinematics with gain and speed-limit rescale.
// ----------------------------------------------------------------------------
// A command is taken on every clock edge where start is high (busy stays low,
// so one command per cycle is sustained). Its four motor speeds and the
// was_scaled flag appear on the o_ ports for one cycle, marked by
// o_result_valid; the receiver cannot hold them off, so it must capture them
// in that cycle. A command passes four kinematics stages, three peak-search
// stages, the rescale divider, which resolves one quotient bit per stage over
// 15 stages, and then the output register.
// rotation_arm (index 0), speed_gain (1) and speed_limit (2) are written
// through the configuration channel, which is always ready; write them only
// while no command is in flight.
`default_nettype none

`include "mecanum_wheel_speed_scaler_unit_defines.svh"

module mecanum_wheel_speed_scaler_unit
    import mwss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command channel
    input  logic                     start,
    output logic                     busy,
    input  logic signed [VEL_W-1:0]  i_velocity_x,
    input  logic signed [VEL_W-1:0]  i_velocity_y,
    input  logic signed [YAW_W-1:0]  i_yaw_rate,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [15:0]              i_cfg_data,
    // result channel
    output logic                     o_result_valid,
    output logic signed [SPD_W-1:0]  o_motor_a_speed,
    output logic signed [SPD_W-1:0]  o_motor_b_speed,
    output logic signed [SPD_W-1:0]  o_motor_c_speed,
    output logic signed [SPD_W-1:0]  o_motor_d_speed,
    output logic                     o_was_scaled
);

    // register indexes
    localparam logic [1:0] CFG_ROTATION_ARM = 2'd0;
    localparam logic [1:0] CFG_SPEED_GAIN   = 2'd1;
    localparam logic [1:0] CFG_SPEED_LIMIT  = 2'd2;

    localparam logic [ARM_W-1:0]   ARM_RESET   = 16'd10240;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd4096;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd8000;

    logic [ARM_W-1:0]            r_rotation_arm;
    logic [GAIN_W-1:0]           r_speed_gain;
    logic [LIMIT_W-1:0]          r_speed_limit;

    t_wheel_mag                  w_wheel;
    t_div_req                    w_req;
    t_div_res                    w_res;

    logic                        r_out_vld;
    logic                        r_was_scaled;
    logic signed [SPD_W-1:0]     r_motor [LANES];
    logic signed [SPD_W-1:0]     n_motor [LANES];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation_arm <= ARM_RESET;
            r_speed_gain   <= GAIN_RESET;
            r_speed_limit  <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROTATION_ARM: begin
                    r_rotation_arm <= i_cfg_data[ARM_W-1:0];
                end
                CFG_SPEED_GAIN: begin
                    r_speed_gain <= i_cfg_data[GAIN_W-1:0];
                end
                CFG_SPEED_LIMIT: begin
                    r_speed_limit <= i_cfg_data[LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mwss_kinematics u_kinematics (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (start && !busy),
        .i_velocity_x   (i_velocity_x),
        .i_velocity_y   (i_velocity_y),
        .i_yaw_rate     (i_yaw_rate),
        .i_rotation_arm (r_rotation_arm),
        .i_speed_gain   (r_speed_gain),
        .o_wheel        (w_wheel)
    );

    mwss_peak u_peak (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wheel       (w_wheel),
        .i_speed_limit (r_speed_limit),
        .o_req         (w_req)
    );

    mwss_rescale u_rescale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    // put the sign back; magnitude is at most 15 bits
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_motor[l] = w_res.neg[l] ? -$signed({1'b0, w_res.quo[l]})
                                      :  $signed({1'b0, w_res.quo[l]});
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld    <= w_res.valid;
            r_was_scaled <= w_res.scaled;
            r_motor      <= n_motor;
        end
    end

    assign o_result_valid  = r_out_vld;
    assign o_was_scaled    = r_was_scaled;
    assign o_motor_a_speed = r_motor[0];
    assign o_motor_b_speed = r_motor[1];
    assign o_motor_c_speed = r_motor[2];
    assign o_motor_d_speed = r_motor[3];

    // every accepted command gives a result after the fixed latency
    `MWSS_ASSERT_DLY(a_result_follows, i_clk, i_rst_n, start && !busy, LATENCY, o_result_valid, "no result after accepted command")

    // no result without a matching command accepted earlier
    `MWSS_ASSERT_IMP(a_no_spurious, i_clk, i_rst_n, o_result_valid, $past(start && !busy, LATENCY), "result without command")

    // magnitudes never exceed 15 bits, so the most negative code never shows
    `MWSS_ASSERT_IMP(a_no_min_code, i_clk, i_rst_n, o_result_valid, (o_motor_a_speed != 16'sh8000) && (o_motor_b_speed != 16'sh8000) && (o_motor_c_speed != 16'sh8000) && (o_motor_d_speed != 16'sh8000), "motor speed out of range")

endmodule

`default_nettype wire

>>> sv/mwss_kinematics.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed scaler: kinematics pipeline
// Four stages: yaw term, wheel linear speeds, gain product, rpm magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module mwss_kinematics
    import mwss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [VEL_W-1:0]  i_velocity_x,
    input  logic signed [VEL_W-1:0]  i_velocity_y,
    input  logic signed [YAW_W-1:0]  i_yaw_rate,
    input  logic [ARM_W-1:0]         i_rotation_arm,
    input  logic [GAIN_W-1:0]        i_speed_gain,
    output t_wheel_mag               o_wheel
);

    logic signed [SUM_W-1:0]  v_x;
    logic signed [SUM_W-1:0]  v_y;
    logic signed [LIN_W-1:0]  v_base_a;
    logic signed [LIN_W-1:0]  v_base_b;
    logic signed [LIN_W-1:0]  v_turn;

    // stage 1 registers
    logic                     r_s1_vld;
    logic signed [SUM_W-1:0]  r_sum_a;
    logic signed [SUM_W-1:0]  r_sum_b;
    logic signed [TURN_W-1:0] r_turn;
    // stage 2 registers
    logic                     r_s2_vld;
    logic signed [LIN_W-1:0]  r_lin  [LANES];
    logic signed [LIN_W-1:0]  n_lin  [LANES];
    // stage 3 registers
    logic                     r_s3_vld;
    logic signed [PROD_W-1:0] r_prod [LANES];
    logic signed [PROD_W-1:0] n_prod [LANES];
    // stage 4 register
    t_wheel_mag               r_wheel;
    t_wheel_mag               n_wheel;

    assign v_x = SUM_W'(i_velocity_x);
    assign v_y = SUM_W'(i_velocity_y);

    // wheel linear speeds with 18 fraction bits
    assign v_base_a = LIN_W'(r_sum_a) <<< LIN_FRAC;
    assign v_base_b = LIN_W'(r_sum_b) <<< LIN_FRAC;
    assign v_turn   = LIN_W'(r_turn);

    always_comb begin
        n_lin[0] = v_base_a + v_turn;
        n_lin[1] = v_base_b - v_turn;
        n_lin[2] = v_base_b + v_turn;
        n_lin[3] = v_base_a - v_turn;
    end

    // gain product, exact
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_prod[l] = PROD_W'(r_lin[l] * $signed({1'b0, i_speed_gain}));
        end
    end

    // truncate toward zero: magnitude shifted down, sign kept apart
    always_comb begin
        logic signed [PROD_W-1:0] v_abs;
        v_abs         = '0;
        n_wheel.valid = r_s3_vld;
        for (int l = 0; l < LANES; l++) begin
            v_abs            = r_prod[l][PROD_W-1] ? -r_prod[l] : r_prod[l];
            n_wheel.mag[l]   = v_abs[FRAC_SHIFT +: MAG_W];
            n_wheel.neg[l]   = r_prod[l][PROD_W-1] ^ FLIP_MASK[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld      <= 1'b0;
            r_s2_vld      <= 1'b0;
            r_s3_vld      <= 1'b0;
            r_wheel.valid <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
            r_sum_a  <= -v_x - v_y;
            r_sum_b  <= v_y - v_x;
            r_turn   <= TURN_W'(i_yaw_rate * $signed({1'b0, i_rotation_arm}));
            r_s2_vld <= r_s1_vld;
            r_lin    <= n_lin;
            r_s3_vld <= r_s2_vld;
            r_prod   <= n_prod;
            r_wheel  <= n_wheel;
        end
    end

    assign o_wheel = r_wheel;

endmodule

`default_nettype wire

>>> sv/mwss_peak.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed scaler: peak search and rescale setup
// Registered max tree over the four magnitudes, limit compare, dividend setup.
// ----------------------------------------------------------------------------
`default_nettype none

module mwss_peak
    import mwss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_wheel_mag          i_wheel,
    input  logic [LIMIT_W-1:0]  i_speed_limit,
    output t_div_req            o_req
);

    // stage A: pairwise maxima
    logic                         r_a_vld;
    logic [LANES-1:0]             r_a_neg;
    logic [LANES-1:0][MAG_W-1:0]  r_a_mag;
    logic [MAG_W-1:0]             r_max_lo;
    logic [MAG_W-1:0]             r_max_hi;
    // stage B: peak and limit compare
    logic                         r_b_vld;
    logic [LANES-1:0]             r_b_neg;
    logic [LANES-1:0][MAG_W-1:0]  r_b_mag;
    logic [MAG_W-1:0]             r_top;
    logic                         r_b_scaled;
    logic [MAG_W-1:0]             n_top;
    // stage C: division request
    t_div_req                     r_req;
    t_div_req                     n_req;

    assign n_top = (r_max_lo > r_max_hi) ? r_max_lo : r_max_hi;

    // unscaled items divide by one so that the quotient is the magnitude
    always_comb begin
        n_req.valid   = r_b_vld;
        n_req.scaled  = r_b_scaled;
        n_req.neg     = r_b_neg;
        n_req.divisor = r_b_scaled ? r_top : MAG_W'(1);
        for (int l = 0; l < LANES; l++) begin
            n_req.num[l] = r_b_scaled ? NUM_W'(r_b_mag[l] * i_speed_limit)
                                      : NUM_W'(r_b_mag[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_req.valid <= 1'b0;
        end else begin
            r_a_vld    <= i_wheel.valid;
            r_a_neg    <= i_wheel.neg;
            r_a_mag    <= i_wheel.mag;
            r_max_lo   <= (i_wheel.mag[0] > i_wheel.mag[1]) ? i_wheel.mag[0]
                                                            : i_wheel.mag[1];
            r_max_hi   <= (i_wheel.mag[2] > i_wheel.mag[3]) ? i_wheel.mag[2]
                                                            : i_wheel.mag[3];
            r_b_vld    <= r_a_vld;
            r_b_neg    <= r_a_neg;
            r_b_mag    <= r_a_mag;
            r_top      <= n_top;
            r_b_scaled <= n_top > MAG_W'(i_speed_limit);
            r_req      <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

`default_nettype wire

>>> sv/mwss_rescale.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed scaler: pipelined rescale divider
// Restoring division, one quotient bit per stage, four wheels in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module mwss_rescale
    import mwss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_div_res  o_res
);

    localparam int STAGES = QUO_W;

    typedef struct packed {
        logic                         valid;
        logic                         scaled;
        logic [LANES-1:0]             neg;
        logic [MAG_W-1:0]             divisor;
        logic [LANES-1:0][NUM_W-1:0]  rem;
        logic [LANES-1:0][QUO_W-1:0]  quo;
    } t_stage;

    t_stage r_stg [STAGES];
    t_stage n_stg [STAGES];

    // stage s settles quotient bit QUO_W-1-s; dividend < divisor * 2^QUO_W
    always_comb begin
        t_stage           v_src;
        logic [NUM_W-1:0] v_trial;
        v_src   = '0;
        v_trial = '0;
        for (int s = 0; s < STAGES; s++) begin
            if (s == 0) begin
                v_src.valid   = i_req.valid;
                v_src.scaled  = i_req.scaled;
                v_src.neg     = i_req.neg;
                v_src.divisor = i_req.divisor;
                v_src.rem     = i_req.num;
                v_src.quo     = '0;
            end else begin
                v_src = r_stg[s-1];
            end
            n_stg[s] = v_src;
            v_trial  = NUM_W'(v_src.divisor) << (QUO_W - 1 - s);
            for (int l = 0; l < LANES; l++) begin
                if (v_src.rem[l] >= v_trial) begin
                    n_stg[s].rem[l]              = v_src.rem[l] - v_trial;
                    n_stg[s].quo[l][QUO_W-1-s]   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                r_stg[s].valid <= 1'b0;
            end
        end else begin
            r_stg <= n_stg;
        end
    end

    assign o_res.valid  = r_stg[STAGES-1].valid;
    assign o_res.scaled = r_stg[STAGES-1].scaled;
    assign o_res.neg    = r_stg[STAGES-1].neg;
    assign o_res.quo    = r_stg[STAGES-1].quo;

endmodule

`default_nettype wire

>>> sim/mecanum_wheel_speed_scaler_unit_tb.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed scaler unit: testbench
// Sends body velocity commands in bursts under several arm, gain and limit
// settings, predicts the four motor speeds and the rescale flag for each
// accepted command, and checks every result strobe against the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_scaler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwss_pkg::*;

    // register indexes on the configuration channel
    localparam logic [1:0] REG_ARM   = 2'd0;
    localparam logic [1:0] REG_GAIN  = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;
    localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped, writes are dropped

    localparam longint LIN_ONE      = longint'(1) << LIN_FRAC;
    localparam int     N_DIRECTED   = 20;
    localparam int     N_PHASES     = 8;
    localparam int     PHASE_ITEMS  = 200;
    localparam int     REPORT_MAX   = 10;
    localparam int     CYCLE_LIMIT  = 200000;

    // one result: four motor speeds and the rescale flag
    typedef struct packed {
        logic signed [SPD_W-1:0] a;
        logic signed [SPD_W-1:0] b;
        logic signed [SPD_W-1:0] c;
        logic signed [SPD_W-1:0] d;
        logic                    scaled;
    } t_motor_set;

    // directed step: settings, command and, where obvious, the answer
    typedef struct {
        logic [15:0]             arm;
        logic [15:0]             gain;
        logic [15:0]             limit;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [YAW_W-1:0] wz;
        bit                      typed;
        int                      a;
        int                      b;
        int                      c;
        int                      d;
        bit                      s;
    } t_step_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic signed [VEL_W-1:0] i_velocity_x = '0;
    logic signed [VEL_W-1:0] i_velocity_y = '0;
    logic signed [YAW_W-1:0] i_yaw_rate = '0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [1:0]              i_cfg_index = '0;
    logic [15:0]             i_cfg_data = '0;
    logic                    o_result_valid;
    logic signed [SPD_W-1:0] o_motor_a_speed;
    logic signed [SPD_W-1:0] o_motor_b_speed;
    logic signed [SPD_W-1:0] o_motor_c_speed;
    logic signed [SPD_W-1:0] o_motor_d_speed;
    logic                    o_was_scaled;

    // local copy of the registers
    logic [ARM_W-1:0]   arm_reg   = 16'd10240;
    logic [GAIN_W-1:0]  gain_reg  = 16'd4096;
    logic [LIMIT_W-1:0] limit_reg = 15'd8000;

    t_motor_set speed_q [$];
    int         mismatch_count = 0;
    int         results_seen   = 0;
    int         scaled_seen    = 0;
    int         cmds_sent      = 0;
    int         settings_used  = 0;
    int         burst_left     = 0;
    int         cycle_count    = 0;

    // straight-through and limit-equal cases are easy to read off by hand
    t_step_row directed_rows [N_DIRECTED] = '{
        '{16'd10240, 16'd4096, 16'd8000,     0,     0,      0, 1,     0,    0,     0,    0, 0},
        '{16'd10240, 16'd4096, 16'd8000,    -1,     0,      0, 1,   -16,   16,   -16,   16, 0},
        '{16'd10240, 16'd4096, 16'd8000,  -500,     0,      0, 1, -8000, 8000, -8000, 8000, 0},
        '{16'd10240, 16'd4096, 16'd8000,  -501,     0,      0, 1, -8000, 8000, -8000, 8000, 1},
        '{16'd10240, 16'd4096, 16'd8000,  4095,     0,      0, 1,  8000,-8000,  8000,-8000, 1},
        '{16'd10240, 16'd4096, 16'd8000, -4096,     0,      0, 1, -8000, 8000, -8000, 8000, 1},
        '{16'd10240, 16'd4096, 16'd8000,     0,  4095,      0, 0,     0,    0,     0,    0, 0},
        '{16'd10240, 16'd4096, 16'd8000,     0, -4096,      0, 0,     0,    0,     0,    0, 0},
        '{16'd10240, 16'd4096, 16'd8000,     0,     0,  32767, 0,     0,    0,     0,    0, 0},
        '{16'd10240, 16'd4096, 16'd8000,     0,     0, -32768, 0,     0,    0,     0,    0, 0},
        '{16'd10240, 16'd4096, 16'd8000,     0,     0,      1, 0,     0,    0,     0,    0, 0},
        '{16'd10240, 16'd4096, 16'd8000,    37,   -21,   -777, 0,     0,    0,     0,    0, 0},
        '{16'd65535, 16'd65535, 16'd32767, -4096, -4096, 32767, 0,    0,    0,     0,    0, 0},
        '{16'd65535, 16'd65535, 16'd32767,  4095,  4095,-32768, 0,    0,    0,     0,    0, 0},
        '{16'd65535, 16'd65535, 16'd32767,  4095, -4096,-32768, 0,    0,    0,     0,    0, 0},
        '{16'd65535, 16'd65535, 16'd32767,    -1,     1,     1, 0,    0,    0,     0,    0, 0},
        '{16'd10240, 16'd4096, 16'd0,       -1,     0,      0, 1,     0,    0,     0,    0, 1},
        '{16'd10240, 16'd4096, 16'd0,        0,     0,      0, 1,     0,    0,     0,    0, 0},
        '{16'd10240, 16'd0,    16'd8000, -4096,  4095,  32767, 1,     0,    0,     0,    0, 0},
        '{16'd0,     16'd4096, 16'd8000,     0,     0,  32767, 1,     0,    0,     0,    0, 0}
    };

    mecanum_wheel_speed_scaler_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_velocity_x    (i_velocity_x),
        .i_velocity_y    (i_velocity_y),
        .i_yaw_rate      (i_yaw_rate),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_valid  (o_result_valid),
        .o_motor_a_speed (o_motor_a_speed),
        .o_motor_b_speed (o_motor_b_speed),
        .o_motor_c_speed (o_motor_c_speed),
        .o_motor_d_speed (o_motor_d_speed),
        .o_was_scaled    (o_was_scaled)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, speed_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // wheel kinematics, gain, limit rescale and clamp, at full width
    function automatic t_motor_set wheel_speeds(input logic signed [VEL_W-1:0] vx,
                                                input logic signed [VEL_W-1:0] vy,
                                                input logic signed [YAW_W-1:0] wz);
        longint     x;
        longint     y;
        longint     turn;
        longint     p;
        longint     mag_v;
        longint     peak;
        longint     lin [LANES];
        longint     rpm [LANES];
        logic signed [SPD_W-1:0] clamped [LANES];
        t_motor_set res;
        x    = vx;
        y    = vy;
        turn = longint'(wz) * longint'(arm_reg);
        lin[0] = (-x - y) * LIN_ONE + turn;
        lin[1] = (-x + y) * LIN_ONE - turn;
        lin[2] = (-x + y) * LIN_ONE + turn;
        lin[3] = (-x - y) * LIN_ONE - turn;
        peak = 0;
        // gain, truncate toward zero, flip motors one and three
        for (int i = 0; i < LANES; i++) begin
            p      = lin[i] * longint'(gain_reg);
            mag_v  = (p < 0 ? -p : p) >> FRAC_SHIFT;
            rpm[i] = (p < 0) ? -mag_v : mag_v;
            if (FLIP_MASK[i])
                rpm[i] = -rpm[i];
            if (mag_v > peak)
                peak = mag_v;
        end
        res.scaled = (peak > longint'(limit_reg));
        for (int i = 0; i < LANES; i++) begin
            if (res.scaled) begin
                mag_v  = (rpm[i] < 0 ? -rpm[i] : rpm[i]) * longint'(limit_reg) / peak;
                rpm[i] = (rpm[i] < 0) ? -mag_v : mag_v;
            end
            if (rpm[i] > 32767)
                clamped[i] = 16'sh7FFF;
            else if (rpm[i] < -32768)
                clamped[i] = 16'sh8000;
            else
                clamped[i] = rpm[i][SPD_W-1:0];
        end
        res.a = clamped[0];
        res.b = clamped[1];
        res.c = clamped[2];
        res.d = clamped[3];
        return res;
    endfunction

    function automatic logic signed [VEL_W-1:0] pick_velocity();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VEL_W'(int'($urandom_range(0, 63)) - 32);
            8:          return 13'sh1000;
            9:          return 13'sh0FFF;
            default:    return VEL_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [YAW_W-1:0] pick_yaw();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return YAW_W'(int'($urandom_range(0, 4095)) - 2048);
            8:          return 16'sh8000;
            9:          return 16'sh7FFF;
            default:    return YAW_W'($urandom);
        endcase
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    // result checker: the receiver takes every strobe
    always @(posedge i_clk) begin : result_check
        t_motor_set got;
        t_motor_set want;
        if (i_rst_n && o_result_valid) begin
            got = '{o_motor_a_speed, o_motor_b_speed, o_motor_c_speed,
                    o_motor_d_speed, o_was_scaled};
            results_seen++;
            if (got.scaled)
                scaled_seen++;
            if (speed_q.size() == 0) begin
                flag_mismatch($sformatf(
                    "unexpected result %0d: a=%0d b=%0d c=%0d d=%0d scaled=%0b",
                    results_seen, got.a, got.b, got.c, got.d, got.scaled));
            end else begin
                want = speed_q.pop_front();
                if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
                    got.d !== want.d || got.scaled !== want.scaled)
                    flag_mismatch($sformatf(
                        "result %0d: expected a=%0d b=%0d c=%0d d=%0d scaled=%0b, got a=%0d b=%0d c=%0d d=%0d scaled=%0b",
                        results_seen, want.a, want.b, want.c, want.d, want.scaled,
                        got.a, got.b, got.c, got.d, got.scaled));
            end
        end
    end

    // one command transfer; the expectation is queued at the accepting edge
    task automatic send_cmd(input logic signed [VEL_W-1:0] vx,
                            input logic signed [VEL_W-1:0] vy,
                            input logic signed [YAW_W-1:0] wz,
                            input t_motor_set want);
        start        <= 1'b1;
        i_velocity_x <= vx;
        i_velocity_y <= vy;
        i_yaw_rate   <= wz;
        do @(posedge i_clk); while (busy);
        speed_q.push_back(want);
        cmds_sent++;
    endtask

    // bursts with random gaps between them
    task automatic pace(input bit allow_gaps);
        if (allow_gaps && burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (speed_q.size() != 0)
            @(posedge i_clk);
    endtask

    // writes all registers back to back, plus the unmapped index
    task automatic program_regs(input logic [15:0] arm, input logic [15:0] gain,
                                input logic [15:0] limit);
        logic [15:0] data [4];
        data[REG_ARM]   = arm;
        data[REG_GAIN]  = gain;
        data[REG_LIMIT] = limit;
        data[REG_SPARE] = 16'($urandom);
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 2'(i);
            i_cfg_data  <= data[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        arm_reg   = arm;
        gain_reg  = gain;
        limit_reg = limit[LIMIT_W-1:0];
        settings_used++;
    endtask

    initial begin : stimulus
        t_step_row   row;
        t_motor_set  want;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [YAW_W-1:0] wz;
        logic [15:0] arm;
        logic [15:0] gain;
        logic [15:0] limit;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settings_used = 1;

        // directed steps, reprogramming only when the row asks for it
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            if (row.arm != arm_reg || row.gain != gain_reg ||
                row.limit[LIMIT_W-1:0] != limit_reg) begin
                wait_idle();
                program_regs(row.arm, row.gain, row.limit);
            end
            if (row.typed)
                want = '{SPD_W'(row.a), SPD_W'(row.b), SPD_W'(row.c),
                         SPD_W'(row.d), row.s};
            else
                want = wheel_speeds(row.vx, row.vy, row.wz);
            send_cmd(row.vx, row.vy, row.wz, want);
            pace(1'b1);
        end

        // random phases: extreme and default settings first, then random ones
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin arm = 16'd0;     gain = 16'hFFFF; limit = 16'hFFFF; end
                1: begin arm = 16'hFFFF;  gain = 16'd1;    limit = 16'd1;    end
                2: begin arm = 16'd10240; gain = 16'd4096; limit = 16'd8000; end
                3: begin arm = 16'hFFFF;  gain = 16'hFFFF; limit = 16'd0;    end
                default: begin
                    arm   = 16'($urandom);
                    gain  = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 1023))
                                                   : 16'($urandom);
                    limit = 16'($urandom);
                end
            endcase
            wait_idle();
            program_regs(arm, gain, limit);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off mid-phase until the pipeline has emptied
                if (ph == 4 && n == PHASE_ITEMS / 2)
                    wait_idle();
                vx = pick_velocity();
                vy = pick_velocity();
                wz = pick_yaw();
                send_cmd(vx, vy, wz, wheel_speeds(vx, vy, wz));
                pace(ph % 3 != 2);
            end
        end

        wait_idle();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (speed_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", speed_q.size()));

        $display("%0d commands under %0d register settings, %0d results checked",
                 cmds_sent, settings_used, results_seen);
        $display("%0d results rescaled to the limit, %0d mismatches",
                 scaled_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
